// ===== hw/rtl/rsi_read_frame_deframer_macros.svh =====
// assertion helpers for the deframer
`ifndef RSI_READ_FRAME_DEFRAMER_MACROS_SVH
`define RSI_READ_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsfd check failed");

// next-cycle implication, checked out of reset
`define RSFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsfd check failed");

`endif

// ===== hw/rtl/rsfd_pkg.sv =====
`default_nettype none

package rsfd_pkg;

	localparam int unsigned HistDepth = 7;

	// header text, oldest byte first
	localparam logic [7:0] HEADER_TEXT [8] = '{8'h52, 8'h53, 8'h49, 8'h5f,
		8'h52, 8'h45, 8'h41, 8'h44};

	typedef struct packed {
		logic [7:0]  frame_type;
		logic [15:0] frame_length;
		logic [7:0]  payload_byte;
		logic [15:0] byte_offset;
		logic        last_of_frame;
		logic        empty_frame;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsfd_parser.sv =====
`default_nettype none

module rsfd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	output logic                  res_valid,
	output rsfd_pkg::result_t     res
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  hist_q [rsfd_pkg::HistDepth];
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic        hdr_match;
	logic        pay_last;
	logic [15:0] len_full;

	// newest previous byte sits in hist_q[0]
	always_comb begin
		hdr_match = (rx_byte == rsfd_pkg::HEADER_TEXT[7]);
		for (int k = 0; k < rsfd_pkg::HistDepth; k++) begin
			if (hist_q[k] != rsfd_pkg::HEADER_TEXT[6 - k]) begin
				hdr_match = 1'b0;
			end
		end
	end

	assign len_full = {rx_byte, len_q[7:0]};
	assign pay_last = ({1'b0, count_q} + 17'd1) >= {1'b0, len_q};

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		len_d     = len_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '{frame_type: type_q, frame_length: len_q, payload_byte: 8'd0,
			byte_offset: 16'd0, last_of_frame: 1'b0, empty_frame: 1'b0};
		case (phase_q)
			PH_TYPE: begin
				type_d  = rx_byte;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d   = {8'd0, rx_byte};
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d   = len_full;
				count_d = 16'd0;
				if (len_full == 16'd0) begin
					res_valid         = 1'b1;
					res.frame_length  = len_full;
					res.last_of_frame = 1'b1;
					res.empty_frame   = 1'b1;
					phase_d           = PH_HUNT;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res_valid         = 1'b1;
				res.payload_byte  = rx_byte;
				res.byte_offset   = count_q;
				res.last_of_frame = pay_last;
				count_d           = count_q + 16'd1;
				if (pay_last) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = hdr_match ? PH_TYPE : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			type_q  <= 8'd0;
			len_q   <= 16'd0;
			count_q <= 16'd0;
			for (int k = 0; k < rsfd_pkg::HistDepth; k++) begin
				hist_q[k] <= 8'd0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			len_q   <= len_d;
			count_q <= count_d;
			hist_q[0] <= rx_byte;
			for (int k = 1; k < rsfd_pkg::HistDepth; k++) begin
				hist_q[k] <= hist_q[k - 1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_read_frame_deframer.sv =====
// header-hunting frame deframer
// s_axis: one received byte per transfer in s_axis_tdata[7:0]
// the block hunts for an eight-byte header text, then takes a type byte,
// a 16-bit length (low byte first) and that many payload bytes
// m_axis: one transfer per payload byte, or one for a zero-length frame
//   m_axis_tdata  type, length, payload byte and offset
//   m_axis_tlast  last transfer of the frame
//   m_axis_tuser  frame had zero length (payload byte and offset are zero)
// header and length bytes give no output transfer
// a byte accepted from s_axis is held in the input register, and its result is
// registered in the output register before it is presented on m_axis
// throughput: one byte per cycle while m_axis does not stall, set by the
// combinational parse step between the input register and the output register
// when m_axis stalls, the output register holds and the input register still
// takes one more byte; s_axis_tready falls once both are full
// reset clears the byte history, the parse state and both valid flags; the
// block starts hunting for a header
`default_nettype none

`include "rsi_read_frame_deframer_macros.svh"

module rsi_read_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// frame_type, frame_length, payload_byte, byte_offset
	output logic [47:0]      m_axis_tdata,
	output logic             m_axis_tlast,  // last_of_frame
	output logic [0:0]       m_axis_tuser   // empty_frame
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              res_free;
	logic              step;
	logic              res_valid;
	rsfd_pkg::result_t res;
	logic              out_valid_q;
	rsfd_pkg::result_t out_q;

	assign res_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && res_free;
	assign s_axis_tready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	rsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_q.byte_offset, out_q.payload_byte,
		out_q.frame_length, out_q.frame_type};
	assign m_axis_tlast    = out_q.last_of_frame;
	assign m_axis_tuser[0] = out_q.empty_frame;

	`RSFD_ASSERT_NOW(a_empty_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
	`RSFD_ASSERT_NOW(a_empty_no_data, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[47:8] == 40'd0)
	`RSFD_ASSERT_NEXT(a_s1_held, valid_s1 && !res_free, valid_s1 && $stable(byte_s1))
	`RSFD_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

`default_nettype wire

// ===== bench/rsi_read_frame_deframer_tb.sv =====
`default_nettype none

module rsi_read_frame_deframer_tb;

	typedef enum logic [2:0] {
		HUNT,
		GET_TYPE,
		GET_LEN_LO,
		GET_LEN_HI,
		IN_PAYLOAD
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// frame_type, frame_length, payload_byte, byte_offset
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;  // last_of_frame
	logic [0:0]  m_axis_tuser;  // empty_frame

	// prediction state
	logic [7:0]        prev_bytes [7];
	parse_phase_t      phase;
	logic [7:0]        cur_type;
	logic [15:0]       cur_length;
	logic [15:0]       bytes_done;
	rsfd_pkg::result_t expected_results [$];

	int unsigned mismatch_count = 0;
	logic        gaps_on = 1'b1;

	rsi_read_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		$display("mismatch %s: expected %0h, got %0h", what, want, got);
		mismatch_count++;
	endtask

	function automatic void reset_prediction();
		for (int k = 0; k < 7; k++) prev_bytes[k] = 8'h00;
		phase = HUNT;
		cur_type = 8'h00;
		cur_length = 16'h0000;
		bytes_done = 16'h0000;
	endfunction

	// advance the frame parser by one byte, queue any result it yields
	function automatic void predict_byte(input logic [7:0] b);
		rsfd_pkg::result_t r;
		logic    hit;
		logic    last;
		hit = (b == rsfd_pkg::HEADER_TEXT[7]);
		for (int k = 0; k < 7; k++) begin
			if (prev_bytes[k] != rsfd_pkg::HEADER_TEXT[6 - k]) hit = 1'b0;
		end
		case (phase)
			GET_TYPE: begin
				cur_type = b;
				phase = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				cur_length = {8'h00, b};
				phase = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				cur_length[15:8] = b;
				bytes_done = 16'h0000;
				if (cur_length == 16'h0000) begin
					r.frame_type = cur_type;
					r.frame_length = cur_length;
					r.payload_byte = 8'h00;
					r.byte_offset = 16'h0000;
					r.last_of_frame = 1'b1;
					r.empty_frame = 1'b1;
					expected_results.push_back(r);
					phase = HUNT;
				end else begin
					phase = IN_PAYLOAD;
				end
			end
			IN_PAYLOAD: begin
				last = ({1'b0, bytes_done} + 17'd1) >= {1'b0, cur_length};
				r.frame_type = cur_type;
				r.frame_length = cur_length;
				r.payload_byte = b;
				r.byte_offset = bytes_done;
				r.last_of_frame = last;
				r.empty_frame = 1'b0;
				expected_results.push_back(r);
				bytes_done = bytes_done + 16'd1;
				if (last) phase = HUNT;
			end
			default: begin
				phase = hit ? GET_TYPE : HUNT;
			end
		endcase
		for (int k = 6; k > 0; k--) prev_bytes[k] = prev_bytes[k - 1];
		prev_bytes[0] = b;
	endfunction

	task automatic check_result();
		rsfd_pkg::result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected transfer, tdata low", 16'h0000, m_axis_tdata[15:0]);
		end else begin
			want = expected_results.pop_front();
			if (m_axis_tdata[7:0] !== want.frame_type)
				report_mismatch("frame_type", 16'(want.frame_type),
					16'(m_axis_tdata[7:0]));
			if (m_axis_tdata[23:8] !== want.frame_length)
				report_mismatch("frame_length", want.frame_length, m_axis_tdata[23:8]);
			if (m_axis_tdata[31:24] !== want.payload_byte)
				report_mismatch("payload_byte", 16'(want.payload_byte),
					16'(m_axis_tdata[31:24]));
			if (m_axis_tdata[47:32] !== want.byte_offset)
				report_mismatch("byte_offset", want.byte_offset, m_axis_tdata[47:32]);
			if (m_axis_tlast !== want.last_of_frame)
				report_mismatch("last_of_frame", 16'(want.last_of_frame),
					16'(m_axis_tlast));
			if (m_axis_tuser[0] !== want.empty_frame)
				report_mismatch("empty_frame", 16'(want.empty_frame),
					16'(m_axis_tuser[0]));
		end
	endtask

	initial reset_prediction();

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) check_result();
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 11);
	end

	task automatic send_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_header();
		for (int k = 0; k < 8; k++) send_byte(rsfd_pkg::HEADER_TEXT[k]);
	endtask

	// resume_header: the previous payload already ended in the first seven header bytes
	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
			input logic resume_header, input logic end_on_prefix);
		int unsigned tail_start;
		tail_start = end_on_prefix ? flen - 7 : flen;
		if (resume_header) send_byte(rsfd_pkg::HEADER_TEXT[7]);
		else send_header();
		send_byte(ftype);
		send_byte(flen[7:0]);
		send_byte(flen[15:8]);
		for (int unsigned i = 0; i < flen; i++) begin
			if (i >= tail_start) send_byte(rsfd_pkg::HEADER_TEXT[i - tail_start]);
			else send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_no_match_from_reset();
		// a lone final header byte against the cleared history
		send_byte(rsfd_pkg::HEADER_TEXT[7]);
		send_byte(8'h00);
	endtask

	task automatic test_field_extremes();
		send_header();
		send_byte(8'hff);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hff);
	endtask

	task automatic test_header_in_payload();
		// header text inside a frame is data; its tail then completes a header after the frame
		send_header();
		send_byte(8'h01);
		send_byte(8'h0f);
		send_byte(8'h00);
		for (int k = 0; k < 8; k++) send_byte(rsfd_pkg::HEADER_TEXT[k]);
		for (int k = 0; k < 7; k++) send_byte(rsfd_pkg::HEADER_TEXT[k]);
		send_frame(8'h5a, 16'h0000, 1'b1, 1'b0);
	endtask

	task automatic test_random_traffic();
		int unsigned frame_bytes;
		int unsigned pick;
		int unsigned n;
		logic [15:0] flen;
		logic        chained;
		logic        resumed;
		logic        long_done;
		frame_bytes = 0;
		long_done = 1'b0;
		while (frame_bytes < 600) begin
			gaps_on = !(frame_bytes >= 200 && frame_bytes < 320);
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				resumed = 1'b0;
				do begin
					n = $urandom_range(0, 99);
					if (!long_done && frame_bytes > 350) begin
						flen = 16'h0100 | 16'($urandom_range(0, 15));
						long_done = 1'b1;
					end else if (n < 15) begin
						flen = 16'h0000;
					end else if (n < 80) begin
						flen = 16'($urandom_range(1, 6));
					end else begin
						flen = 16'($urandom_range(7, 40));
					end
					chained = (flen >= 7) && ($urandom_range(0, 3) == 0);
					send_frame(8'($urandom_range(0, 255)), flen, resumed, chained);
					frame_bytes += (resumed ? 4 : 11) + flen;
					resumed = chained;
				end while (chained);
			end else if (pick < 80) begin
				n = $urandom_range(1, 6);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				n = $urandom_range(1, 7);
				for (int k = 0; k < n; k++) send_byte(rsfd_pkg::HEADER_TEXT[k]);
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(0, 7);
				for (int k = 0; k < 8; k++) begin
					if (k == n) send_byte(8'($urandom_range(0, 255)));
					else send_byte(rsfd_pkg::HEADER_TEXT[k]);
				end
				repeat (3) send_byte(8'($urandom_range(0, 255)));
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		int unsigned drain_cycles;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_match_from_reset();
		test_field_extremes();
		test_header_in_payload();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;
		drain_cycles = 0;
		while (expected_results.size() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (expected_results.size() != 0)
			report_mismatch("results never arrived, count", 16'h0000,
				16'(expected_results.size()));
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
